/* hdl/bitmap_page_frame_allocator_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bpfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_pkg
// Types, codes and helper functions of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int KIND_W   = 3;
  localparam int PAGE_W   = 16;
  localparam int COUNT_W  = 17;
  localparam int STATUS_W = 2;
  localparam int SPAN_W   = 18;           // page index plus run end
  localparam int WIDX_W   = SPAN_W - 6;   // 64-page word index
  localparam int POP_W    = 7;

  localparam logic [KIND_W-1:0] KIND_REQUEST   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOCK      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UNRESERVE = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

  localparam logic [COUNT_W-1:0] CNT_MAX = 17'h1FFFF;
  localparam logic [COUNT_W-1:0] TOTAL_RESET = 17'h10000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_COUNT,
    ST_FINISH
  } state_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [5:0] ffs64(input logic [63:0] x);
    logic [63:0] low;
    logic [5:0]  idx;
    low = x & (~x + 64'd1);
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      if (low[i]) idx = idx | 6'(i);
    end
    return idx;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] x);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + {3'd0, x[i]};
    return n;
  endfunction

  function automatic logic [POP_W-1:0] pop64(input logic [63:0] x);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + {3'd0, pop8(x[i*8 +: 8])};
    return n;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] c,
                                                 input logic [POP_W-1:0] n);
    logic [COUNT_W:0] s;
    s = {1'b0, c} + {{(COUNT_W+1-POP_W){1'b0}}, n};
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[COUNT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] sat_sub(input logic [COUNT_W-1:0] c,
                                                 input logic [POP_W-1:0] n);
    logic [COUNT_W-1:0] nw;
    nw = {{(COUNT_W-POP_W){1'b0}}, n};
    return (c < nw) ? '0 : c - nw;
  endfunction

endpackage

/* hdl/bpfa_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_req_if / bpfa_rsp_if
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface bpfa_req_if;
  import bpfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PAGE_W-1:0]   first_page;
  logic [COUNT_W-1:0]  page_count;

  modport source (output valid, kind, first_page, page_count, input ready);
  modport sink   (input valid, kind, first_page, page_count, output ready);
endinterface

interface bpfa_rsp_if;
  import bpfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   page_number;
  logic [COUNT_W-1:0]  changed_pages;
  logic [COUNT_W-1:0]  free_pages;
  logic [COUNT_W-1:0]  used_pages;
  logic [COUNT_W-1:0]  reserved_pages;

  modport source (output valid, status, page_number, changed_pages, free_pages,
                  used_pages, reserved_pages, input ready);
  modport sink   (input valid, status, page_number, changed_pages, free_pages,
                  used_pages, reserved_pages, output ready);
endinterface

/* hdl/bitmap_page_frame_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// One bit per page frame in a word-wide RAM, with a next-free search hint.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : request channel (kind, first_page, page_count), valid/ready.
//   out_rsp : one result per request (status, page number, changed count and
//             the free/used/reserved totals after the operation).
//   cfg_we / cfg_wdata : writes total_pages; only while the block is idle.
// The bitmap lives in a RAM of 64-page words (MAX_PAGES/64 rows). Each request
// is worked on alone with read-modify-write of one word at a time:
//   request (alloc) : read, then evaluate, each 64-page word from the hint on.
//   free/lock/reserve/unreserve : read, modify, count each word of the run.
//   zero-length, unknown kind or nothing in range : straight to the result.
// The RAM read port (one word per read, registered) sets the pace.
// At reset the used and reserved counters and the hint clear and a clearing
// pass writes zero to every RAM row, one row per cycle; no request is taken
// meanwhile, config writes are. The result sits in an output
// register: a stalled receiver holds it, the next request may still enter and
// run, and only its write to the output register waits for the slot.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
  parameter int MAX_PAGES = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bpfa_req_if.sink                     in_req,
  bpfa_rsp_if.source                   out_rsp,
  input  logic                         cfg_we,
  input  logic [bpfa_pkg::COUNT_W-1:0] cfg_wdata
);
  import bpfa_pkg::*;

  localparam int WORDS = (MAX_PAGES + 63) / 64;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CAP   = (MAX_PAGES > 131071) ? 131071 : MAX_PAGES;
  localparam logic [COUNT_W-1:0] CAP_PAGES = COUNT_W'(CAP);
  localparam logic [AW-1:0] LAST_ROW = AW'(WORDS - 1);

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]  total_r;
  logic [COUNT_W-1:0]  hint_r, hint_nxt;
  logic [COUNT_W-1:0]  used_r, used_nxt;
  logic [COUNT_W-1:0]  rsv_r, rsv_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [WIDX_W-1:0]   widx_r, widx_nxt;
  logic [WIDX_W-1:0]   lastw_r, lastw_nxt;
  logic [5:0]          lo_r, lo_nxt;
  logic [5:0]          hi_r, hi_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [COUNT_W-1:0]  changed_r, changed_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [63:0]         diff_r, diff_nxt;
  logic [AW-1:0]       clr_addr_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [PAGE_W-1:0]   out_page_r;
  logic [COUNT_W-1:0]  out_changed_r, out_free_r, out_used_r, out_rsv_r;
  logic                out_load;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr, widx_addr;
  logic [63:0]         ram_wdata, ram_rdata;
  logic [WIDX_W+AW-1:0] addr_ext;

  // Run and limit arithmetic
  logic [COUNT_W-1:0] limit, limit_m1;
  logic [SPAN_W-1:0]  limit18, run_sum, run_end, run_end_m1;
  logic               in_fire;
  logic [5:0]         hi_eff;
  logic [63:0]        word_mask, free_bits, diff_word;
  logic [5:0]         free_idx, diff_idx;
  logic [SPAN_W-1:0]  found_page, diff_page;
  logic [POP_W-1:0]   diff_cnt;
  logic               setting;
  logic [SPAN_W-1:0]  taken;
  logic [COUNT_W-1:0] free_now;

  assign in_fire  = in_req.valid && in_req.ready;
  assign limit    = (total_r > CAP_PAGES) ? CAP_PAGES : total_r;
  assign limit_m1 = limit - COUNT_W'(1);
  assign limit18  = {1'b0, limit};
  assign run_sum  = {2'b00, in_req.first_page} + {1'b0, in_req.page_count};
  assign run_end  = (run_sum > limit18) ? limit18 : run_sum;
  assign run_end_m1 = run_end - SPAN_W'(1);

  // Pages of the current word that the operation covers
  assign hi_eff    = (widx_r == lastw_r) ? hi_r : 6'd63;
  assign word_mask = ({64{1'b1}} << lo_r) & ({64{1'b1}} >> (6'd63 - hi_eff));
  assign free_bits = ~ram_rdata & word_mask;
  assign free_idx  = ffs64(free_bits);
  assign found_page = {widx_r, free_idx};
  assign setting   = (kind_r == KIND_LOCK) || (kind_r == KIND_RESERVE);
  assign diff_word = word_mask & (ram_rdata ^ {64{setting}});

  assign diff_cnt  = pop64(diff_r);
  assign diff_idx  = ffs64(diff_r);
  assign diff_page = {widx_r, diff_idx};

  assign taken    = {1'b0, used_r} + {1'b0, rsv_r};
  assign free_now = (taken >= limit18) ? '0 : COUNT_W'(limit18 - taken);

  assign addr_ext  = {{AW{1'b0}}, widx_r};
  assign widx_addr = addr_ext[AW-1:0];

  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_rsp.ready);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ROW) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req.kind == KIND_REQUEST) begin
            state_nxt = (hint_r >= limit) ? ST_FINISH : ST_READ;
          end else if (in_req.kind <= KIND_UNRESERVE) begin
            if (in_req.page_count == '0 || {2'b00, in_req.first_page} >= run_end)
              state_nxt = ST_FINISH;
            else
              state_nxt = ST_READ;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (kind_r != KIND_REQUEST) state_nxt = ST_COUNT;
        else if (free_bits != '0 || widx_r == lastw_r) state_nxt = ST_FINISH;
        else state_nxt = ST_READ;
      end
      ST_COUNT: begin
        state_nxt = (widx_r == lastw_r) ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and RAM control
  // --------------------------------------------------------------------------
  always_comb begin
    hint_nxt    = hint_r;
    used_nxt    = used_r;
    rsv_nxt     = rsv_r;
    kind_nxt    = kind_r;
    widx_nxt    = widx_r;
    lastw_nxt   = lastw_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    status_nxt  = status_r;
    changed_nxt = changed_r;
    page_nxt    = page_r;
    diff_nxt    = diff_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = widx_addr;
    ram_raddr   = widx_addr;
    ram_wdata   = ram_rdata ^ diff_word;
    out_valid_nxt = out_valid_r;
    if (out_rsp.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt    = in_req.kind;
          changed_nxt = '0;
          page_nxt    = '0;
          status_nxt  = STATUS_OK;
          if (in_req.kind == KIND_REQUEST) begin
            if (hint_r >= limit) begin
              status_nxt = STATUS_NOFREE;
              hint_nxt   = limit;
            end
            widx_nxt  = {1'b0, hint_r[COUNT_W-1:6]};
            lastw_nxt = {1'b0, limit_m1[COUNT_W-1:6]};
            lo_nxt    = hint_r[5:0];
            hi_nxt    = limit_m1[5:0];
          end else if (in_req.kind <= KIND_UNRESERVE) begin
            if (in_req.page_count != '0 && run_sum > limit18) status_nxt = STATUS_RANGE;
            widx_nxt  = {2'b00, in_req.first_page[PAGE_W-1:6]};
            lastw_nxt = run_end_m1[SPAN_W-1:6];
            lo_nxt    = in_req.first_page[5:0];
            hi_nxt    = run_end_m1[5:0];
          end
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_EVAL: begin
        if (kind_r == KIND_REQUEST) begin
          if (free_bits != '0) begin
            ram_we      = 1'b1;
            ram_wdata   = ram_rdata | (64'd1 << free_idx);
            page_nxt    = found_page[PAGE_W-1:0];
            hint_nxt    = found_page[COUNT_W-1:0];
            used_nxt    = sat_add(used_r, POP_W'(1));
            changed_nxt = COUNT_W'(1);
          end else if (widx_r == lastw_r) begin
            status_nxt = STATUS_NOFREE;
            hint_nxt   = limit;
          end else begin
            widx_nxt = widx_r + WIDX_W'(1);
            lo_nxt   = '0;
          end
        end else begin
          ram_we   = 1'b1;
          diff_nxt = diff_word;
        end
      end
      ST_COUNT: begin
        changed_nxt = changed_r + {{(COUNT_W-POP_W){1'b0}}, diff_cnt};
        priority case (kind_r)
          KIND_LOCK:    used_nxt = sat_add(used_r, diff_cnt);
          KIND_RESERVE: rsv_nxt  = sat_add(rsv_r, diff_cnt);
          KIND_FREE:    used_nxt = sat_sub(used_r, diff_cnt);
          default:      rsv_nxt  = sat_sub(rsv_r, diff_cnt);
        endcase
        // clearing a bit pulls the hint down to the lowest cleared page
        if (!setting && diff_r != '0 && diff_page[COUNT_W-1:0] < hint_r)
          hint_nxt = diff_page[COUNT_W-1:0];
        widx_nxt = widx_r + WIDX_W'(1);
        lo_nxt   = '0;
      end
      ST_FINISH: begin
        if (out_load) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      total_r     <= TOTAL_RESET;
      hint_r      <= '0;
      used_r      <= '0;
      rsv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_we) total_r <= cfg_wdata;
      hint_r      <= hint_nxt;
      used_r      <= used_nxt;
      rsv_r       <= rsv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    widx_r    <= widx_nxt;
    lastw_r   <= lastw_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    status_r  <= status_nxt;
    changed_r <= changed_nxt;
    page_r    <= page_nxt;
    diff_r    <= diff_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_page_r    <= page_r;
      out_changed_r <= changed_r;
      out_free_r    <= free_now;
      out_used_r    <= used_r;
      out_rsv_r     <= rsv_r;
    end
  end

  bpfa_ram #(
    .WIDTH (64),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready           = (state_r == ST_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.page_number    = out_page_r;
  assign out_rsp.changed_pages  = out_changed_r;
  assign out_rsp.free_pages     = out_free_r;
  assign out_rsp.used_pages     = out_used_r;
  assign out_rsp.reserved_pages = out_rsv_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_macros.svh"

  `BPFA_ASSERT_NOW(a_write_states, clk, rst_n, ram_we,
    state_r == ST_CLEAR || state_r == ST_EVAL, "bitmap written outside clear/modify")
  `BPFA_ASSERT_NOW(a_alloc_one_bit, clk, rst_n,
    ram_we && state_r == ST_EVAL && kind_r == KIND_REQUEST,
    $countones(ram_wdata ^ ram_rdata) == 1, "allocation must set exactly one bit")
  `BPFA_ASSERT_NOW(a_run_in_mask, clk, rst_n,
    ram_we && state_r == ST_EVAL && kind_r != KIND_REQUEST,
    ((ram_wdata ^ ram_rdata) & ~word_mask) == '0, "run touched bits outside its span")
  `BPFA_ASSERT_NEXT(a_modify_then_count, clk, rst_n,
    state_r == ST_EVAL && kind_r != KIND_REQUEST,
    state_r == ST_COUNT, "range word not followed by count step")

endmodule

/* hdl/bpfa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
